### hw/rtl/cco_pkg.sv
// Shared constants and types for the capsule overlap pipeline.
`timescale 1ns / 1ps
`default_nettype none
package cco_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int REG_W          = 31;
  localparam int CHUNK_W        = 31;
  localparam int CFG_IDX_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVING_RADIUS      = 1'b0,
    CFG_PARALLEL_THRESHOLD = 1'b1
  } cfg_idx_e;

endpackage
`default_nettype wire

### hw/rtl/cco_mul.sv
// Two-stage signed multiplier built from registered 32 by 32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module cco_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int PW = 64
) (
  input  logic                 clk_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [PW-1:0] p_o
);
  import cco_pkg::*;

  localparam int NA  = (AW + CHUNK_W - 1) / CHUNK_W;
  localparam int NB  = (BW + CHUNK_W - 1) / CHUNK_W;
  localparam int PPW = 2 * CHUNK_W + 2;

  logic signed [NA*CHUNK_W-1:0] a_x;
  logic signed [NB*CHUNK_W-1:0] b_x;
  logic signed [CHUNK_W:0]      ac [NA];
  logic signed [CHUNK_W:0]      bc [NB];
  logic signed [PPW-1:0]        pp_q [NA][NB];
  logic signed [PW-1:0]         acc;

  assign a_x = (NA*CHUNK_W)'(a_i);
  assign b_x = (NB*CHUNK_W)'(b_i);

  for (genvar i = 0; i < NA; i++) begin : g_ac
    if (i == NA - 1) begin : g_top
      assign ac[i] = {a_x[NA*CHUNK_W-1], a_x[i*CHUNK_W +: CHUNK_W]};
    end else begin : g_low
      assign ac[i] = {1'b0, a_x[i*CHUNK_W +: CHUNK_W]};
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_bc
    if (j == NB - 1) begin : g_top
      assign bc[j] = {b_x[NB*CHUNK_W-1], b_x[j*CHUNK_W +: CHUNK_W]};
    end else begin : g_low
      assign bc[j] = {1'b0, b_x[j*CHUNK_W +: CHUNK_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_q[i][j] <= ac[i] * bc[j];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp_q[i][j]) <<< (CHUNK_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= acc;
  end

endmodule
`default_nettype wire

### hw/rtl/cco_div.sv
// Pipelined restoring divider giving a quotient clamped to [0,1] in fixed point.
`timescale 1ns / 1ps
`default_nettype none
module cco_div #(
  parameter int W         = 101,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic signed [W-1:0]  num_i,
  input  logic signed [W-1:0]  den_i,
  output logic [FRAC_BITS:0]   q_o
);
  import cco_pkg::*;

  logic                 zf0_q;
  logic [W-1:0]         an0_q;
  logic [W-1:0]         ad0_q;
  logic [W:0]           rem_q [FRAC_BITS+1];
  logic [W-1:0]         dd_q  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] qq_q  [FRAC_BITS+1];
  logic                 zf_q  [FRAC_BITS+1];
  logic                 of_q  [FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    zf0_q <= (den_i == '0) || (num_i == '0) || (num_i[W-1] != den_i[W-1]);
    an0_q <= num_i[W-1] ? W'(-num_i) : W'(num_i);
    ad0_q <= den_i[W-1] ? W'(-den_i) : W'(den_i);
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {1'b0, an0_q};
    dd_q[0]  <= ad0_q;
    qq_q[0]  <= '0;
    zf_q[0]  <= zf0_q;
    of_q[0]  <= an0_q >= ad0_q;
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [W:0] sh;
    logic       ge;
    assign sh = {rem_q[k-1][W-1:0], 1'b0};
    assign ge = sh >= {1'b0, dd_q[k-1]};
    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? sh - {1'b0, dd_q[k-1]} : sh;
      dd_q[k]  <= dd_q[k-1];
      qq_q[k]  <= {qq_q[k-1][FRAC_BITS-2:0], ge};
      zf_q[k]  <= zf_q[k-1];
      of_q[k]  <= of_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (zf_q[FRAC_BITS]) begin
      q_o <= '0;
    end else if (of_q[FRAC_BITS]) begin
      q_o <= (FRAC_BITS+1)'(1) << FRAC_BITS;
    end else begin
      q_o <= {1'b0, qq_q[FRAC_BITS]};
    end
  end

  assert property (@(posedge clk_i) zf_q[FRAC_BITS] |=> (q_o == '0))
    else $error("Quotient is not zero for a zero or sign-mismatched item.");

endmodule
`default_nettype wire

### hw/rtl/cco_delay.sv
// Delay line that carries side data and a valid bit alongside a pipelined unit.
`timescale 1ns / 1ps
`default_nettype none
module cco_delay #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         vld_i,
  input  logic [W-1:0] dat_i,
  output logic         vld_o,
  output logic [W-1:0] dat_o
);
  import cco_pkg::*;

  logic [D-1:0] vld_q;
  logic [W-1:0] dat_q [D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < D; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q[0] <= dat_i;
    for (int k = 1; k < D; k++) begin
      dat_q[k] <= dat_q[k-1];
    end
  end

  assign vld_o = vld_q[D-1];
  assign dat_o = dat_q[D-1];

endmodule
`default_nettype wire

### hw/rtl/capsule_capsule_overlap_test.sv
// Throughput: one item per cycle; every stage advances each cycle and busy stays low.
// The two restoring dividers produce one quotient bit per stage.
// Reset clears the valid pipeline, sets moving_radius to 0 and parallel_threshold to 1.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module capsule_capsule_overlap_test #(
  parameter int COORD_BITS = cco_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = cco_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  seg_start_x_i,
  input  logic signed [COORD_BITS-1:0]  seg_start_y_i,
  input  logic signed [COORD_BITS-1:0]  seg_start_z_i,
  input  logic signed [COORD_BITS-1:0]  seg_end_x_i,
  input  logic signed [COORD_BITS-1:0]  seg_end_y_i,
  input  logic signed [COORD_BITS-1:0]  seg_end_z_i,
  input  logic signed [COORD_BITS-1:0]  target_base_x_i,
  input  logic signed [COORD_BITS-1:0]  target_base_y_i,
  input  logic signed [COORD_BITS-1:0]  target_base_z_i,
  input  logic [cco_pkg::REG_W-1:0]     target_height_i,
  input  logic [cco_pkg::REG_W-1:0]     target_radius_i,
  input  logic                          cfg_we_i,
  input  logic [cco_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cco_pkg::REG_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic                          overlap_o
);
  import cco_pkg::*;

  localparam int UW   = COORD_BITS + 1;
  localparam int RW   = REG_W;
  localparam int HW   = RW + 1;
  localparam int RSW  = RW + 1;
  localparam int M1W  = 2 * UW;
  localparam int QW   = 2 * COORD_BITS + 3;
  localparam int HHW  = 2 * HW;
  localparam int UHW  = UW + HW;
  localparam int BPW  = UW + QW;
  localparam int NTW  = BPW + 1;
  localparam int HQW  = HW + QW;
  localparam int DETW = HHW + QW;
  localparam int DVW  = (NTW > HQW) ? NTW : HQW;
  localparam int TW0  = RW + 3 * FRAC_BITS + 1;
  localparam int TW   = ((DETW > TW0) ? DETW : TW0) + 1;
  localparam int SCW  = FRAC_BITS + 2;
  localparam int PCW  = UW + SCW;
  localparam int HTW  = HW + SCW;
  localparam int MW   = (UW > HW) ? UW : HW;
  localparam int CW   = MW + SCW + 2;
  localparam int SQW  = 2 * CW;
  localparam int DDW  = SQW + 2;
  localparam int LSW  = RSW + FRAC_BITS + 1;
  localparam int LIMW = 2 * LSW;
  localparam int CMPW = ((DDW > LIMW) ? DDW : LIMW) + 1;
  localparam int CPW  = UW + HW;
  localparam int SAW  = 6 * UW + RW + RSW;
  localparam int SBW  = 3 * QW + UHW + SAW;
  localparam int SCDW = 3 * UW + RSW;
  localparam int LATENCY = 16 + FRAC_BITS;

  logic [RW-1:0] mr_q;
  logic [RW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mr_q  <= '0;
      thr_q <= RW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MOVING_RADIUS:      mr_q  <= cfg_wdata_i;
        CFG_PARALLEL_THRESHOLD: thr_q <= cfg_wdata_i;
      endcase
    end
  end

  assign busy = 1'b0;

  // Difference vectors.
  logic signed [UW-1:0] u1_q [3];
  logic signed [UW-1:0] w1_q [3];
  logic [RW-1:0]        h1_q;
  logic [RSW-1:0]       rs1_q;
  logic                 vld1_q;
  logic signed [HW-1:0] hs1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q[0] <= UW'(seg_end_x_i) - UW'(seg_start_x_i);
    u1_q[1] <= UW'(seg_end_y_i) - UW'(seg_start_y_i);
    u1_q[2] <= UW'(seg_end_z_i) - UW'(seg_start_z_i);
    w1_q[0] <= UW'(seg_start_x_i) - UW'(target_base_x_i);
    w1_q[1] <= UW'(seg_start_y_i) - UW'(target_base_y_i);
    w1_q[2] <= UW'(seg_start_z_i) - UW'(target_base_z_i);
    h1_q    <= target_height_i;
    rs1_q   <= RSW'(mr_q) + RSW'(target_radius_i);
  end

  assign hs1 = {1'b0, h1_q};

  // First products.
  logic signed [M1W-1:0] uxux, uzuz, uxwx, uzwz, uywy;
  logic signed [HHW-1:0] hh;
  logic signed [UHW-1:0] uyh;

  cco_mul #(.AW(UW), .BW(UW), .PW(M1W)) u_mul_uxux (
    .clk_i, .a_i(u1_q[0]), .b_i(u1_q[0]), .p_o(uxux));
  cco_mul #(.AW(UW), .BW(UW), .PW(M1W)) u_mul_uzuz (
    .clk_i, .a_i(u1_q[2]), .b_i(u1_q[2]), .p_o(uzuz));
  cco_mul #(.AW(UW), .BW(UW), .PW(M1W)) u_mul_uxwx (
    .clk_i, .a_i(u1_q[0]), .b_i(w1_q[0]), .p_o(uxwx));
  cco_mul #(.AW(UW), .BW(UW), .PW(M1W)) u_mul_uzwz (
    .clk_i, .a_i(u1_q[2]), .b_i(w1_q[2]), .p_o(uzwz));
  cco_mul #(.AW(UW), .BW(UW), .PW(M1W)) u_mul_uywy (
    .clk_i, .a_i(u1_q[1]), .b_i(w1_q[1]), .p_o(uywy));
  cco_mul #(.AW(HW), .BW(HW), .PW(HHW)) u_mul_hh (
    .clk_i, .a_i(hs1), .b_i(hs1), .p_o(hh));
  cco_mul #(.AW(UW), .BW(HW), .PW(UHW)) u_mul_uyh (
    .clk_i, .a_i(u1_q[1]), .b_i(hs1), .p_o(uyh));

  logic [SAW-1:0]       sa_o;
  logic                 vld3;
  logic signed [UW-1:0] u3 [3];
  logic signed [UW-1:0] w3 [3];
  logic [RW-1:0]        h3;
  logic [RSW-1:0]       rs3;

  cco_delay #(.W(SAW), .D(2)) u_dly_a (
    .clk_i, .rst_ni, .vld_i(vld1_q),
    .dat_i({u1_q[0], u1_q[1], u1_q[2], w1_q[0], w1_q[1], w1_q[2], h1_q, rs1_q}),
    .vld_o(vld3), .dat_o(sa_o));

  assign {u3[0], u3[1], u3[2], w3[0], w3[1], w3[2], h3, rs3} = sa_o;

  // Dot-product sums.
  logic signed [QW-1:0]  q4_q, p4_q, d4_q;
  logic signed [HHW-1:0] hh4_q;
  logic signed [UHW-1:0] uyh4_q;
  logic signed [UW-1:0]  u4_q [3];
  logic signed [UW-1:0]  w4_q [3];
  logic [RW-1:0]         h4_q;
  logic [RSW-1:0]        rs4_q;
  logic                  vld4_q;
  logic signed [HW-1:0]  hs4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld3;
    end
  end

  always_ff @(posedge clk_i) begin
    q4_q   <= QW'(uxux) + QW'(uzuz);
    p4_q   <= QW'(uxwx) + QW'(uzwz);
    d4_q   <= QW'(uxwx) + QW'(uzwz) + QW'(uywy);
    hh4_q  <= hh;
    uyh4_q <= uyh;
    for (int k = 0; k < 3; k++) begin
      u4_q[k] <= u3[k];
      w4_q[k] <= w3[k];
    end
    h4_q  <= h3;
    rs4_q <= rs3;
  end

  assign hs4 = {1'b0, h4_q};

  // Second products.
  logic signed [BPW-1:0]  wyq, uyp;
  logic signed [HQW-1:0]  hq;
  logic signed [DETW-1:0] det;

  cco_mul #(.AW(UW), .BW(QW), .PW(BPW)) u_mul_wyq (
    .clk_i, .a_i(w4_q[1]), .b_i(q4_q), .p_o(wyq));
  cco_mul #(.AW(UW), .BW(QW), .PW(BPW)) u_mul_uyp (
    .clk_i, .a_i(u4_q[1]), .b_i(p4_q), .p_o(uyp));
  cco_mul #(.AW(HW), .BW(QW), .PW(HQW)) u_mul_hq (
    .clk_i, .a_i(hs4), .b_i(q4_q), .p_o(hq));
  cco_mul #(.AW(HHW), .BW(QW), .PW(DETW)) u_mul_det (
    .clk_i, .a_i(hh4_q), .b_i(q4_q), .p_o(det));

  logic [SBW-1:0]        sb_o;
  logic                  vld6;
  logic signed [QW-1:0]  q6, p6, d6;
  logic signed [UHW-1:0] uyh6;
  logic signed [UW-1:0]  u6 [3];
  logic signed [UW-1:0]  w6 [3];
  logic [RW-1:0]         h6;
  logic [RSW-1:0]        rs6;

  cco_delay #(.W(SBW), .D(2)) u_dly_b (
    .clk_i, .rst_ni, .vld_i(vld4_q),
    .dat_i({q4_q, p4_q, d4_q, uyh4_q, u4_q[0], u4_q[1], u4_q[2],
            w4_q[0], w4_q[1], w4_q[2], h4_q, rs4_q}),
    .vld_o(vld6), .dat_o(sb_o));

  assign {q6, p6, d6, uyh6, u6[0], u6[1], u6[2], w6[0], w6[1], w6[2], h6, rs6} = sb_o;

  // Parallel test and divider operand selection.
  logic signed [NTW-1:0] nt;
  logic signed [TW-1:0]  det_x, thr_x;
  logic signed [HW-1:0]  hs6;
  logic                  par, hpos, bgc;
  logic signed [DVW-1:0] scn_d, scd_d, tcn_d, tcd_d;

  assign nt    = NTW'(wyq) - NTW'(uyp);
  assign det_x = TW'(det);
  assign thr_x = TW'(thr_q) << (3 * FRAC_BITS);
  assign par   = det_x < thr_x;
  assign hs6   = {1'b0, h6};
  assign hpos  = |h6;
  assign bgc   = hpos && (CPW'(u6[1]) > CPW'(hs6));

  always_comb begin
    scn_d = -DVW'(p6);
    scd_d = (par || !hpos) ? '0 : DVW'(q6);
    if (par) begin
      if (bgc) begin
        tcn_d = DVW'(d6);
        tcd_d = DVW'(uyh6);
      end else begin
        tcn_d = DVW'(w6[1]);
        tcd_d = DVW'(hs6);
      end
    end else begin
      tcn_d = DVW'(nt);
      tcd_d = DVW'(hq);
    end
  end

  logic signed [DVW-1:0] scn_q, scd_q, tcn_q, tcd_q;
  logic signed [UW-1:0]  u7_q [3];
  logic signed [UW-1:0]  w7_q [3];
  logic [RW-1:0]         h7_q;
  logic [RSW-1:0]        rs7_q;
  logic                  vld7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld7_q <= 1'b0;
    end else begin
      vld7_q <= vld6;
    end
  end

  always_ff @(posedge clk_i) begin
    scn_q <= scn_d;
    scd_q <= scd_d;
    tcn_q <= tcn_d;
    tcd_q <= tcd_d;
    for (int k = 0; k < 3; k++) begin
      u7_q[k] <= u6[k];
      w7_q[k] <= w6[k];
    end
    h7_q  <= h6;
    rs7_q <= rs6;
  end

  // Closest-point parameters.
  logic [FRAC_BITS:0] sc, tc;

  cco_div #(.W(DVW), .FRAC_BITS(FRAC_BITS)) u_div_sc (
    .clk_i, .num_i(scn_q), .den_i(scd_q), .q_o(sc));
  cco_div #(.W(DVW), .FRAC_BITS(FRAC_BITS)) u_div_tc (
    .clk_i, .num_i(tcn_q), .den_i(tcd_q), .q_o(tc));

  logic [SAW-1:0]       sd_o;
  logic                 vld10;
  logic signed [UW-1:0] u10 [3];
  logic signed [UW-1:0] w10 [3];
  logic [RW-1:0]        h10;
  logic [RSW-1:0]       rs10;

  cco_delay #(.W(SAW), .D(FRAC_BITS + 3)) u_dly_d (
    .clk_i, .rst_ni, .vld_i(vld7_q),
    .dat_i({u7_q[0], u7_q[1], u7_q[2], w7_q[0], w7_q[1], w7_q[2], h7_q, rs7_q}),
    .vld_o(vld10), .dat_o(sd_o));

  assign {u10[0], u10[1], u10[2], w10[0], w10[1], w10[2], h10, rs10} = sd_o;

  // Closest-point offsets.
  logic signed [SCW-1:0] sc_s, tc_s;
  logic signed [HW-1:0]  hs10;
  logic signed [PCW-1:0] uxs, uys, uzs;
  logic signed [HTW-1:0] htc;

  assign sc_s = {1'b0, sc};
  assign tc_s = {1'b0, tc};
  assign hs10 = {1'b0, h10};

  cco_mul #(.AW(UW), .BW(SCW), .PW(PCW)) u_mul_uxs (
    .clk_i, .a_i(u10[0]), .b_i(sc_s), .p_o(uxs));
  cco_mul #(.AW(UW), .BW(SCW), .PW(PCW)) u_mul_uys (
    .clk_i, .a_i(u10[1]), .b_i(sc_s), .p_o(uys));
  cco_mul #(.AW(UW), .BW(SCW), .PW(PCW)) u_mul_uzs (
    .clk_i, .a_i(u10[2]), .b_i(sc_s), .p_o(uzs));
  cco_mul #(.AW(HW), .BW(SCW), .PW(HTW)) u_mul_htc (
    .clk_i, .a_i(hs10), .b_i(tc_s), .p_o(htc));

  logic [SCDW-1:0]      sc2_o;
  logic                 vld12;
  logic signed [UW-1:0] w12 [3];
  logic [RSW-1:0]       rs12;

  cco_delay #(.W(SCDW), .D(2)) u_dly_c (
    .clk_i, .rst_ni, .vld_i(vld10),
    .dat_i({w10[0], w10[1], w10[2], rs10}),
    .vld_o(vld12), .dat_o(sc2_o));

  assign {w12[0], w12[1], w12[2], rs12} = sc2_o;

  // Separation vector.
  logic signed [CW-1:0] c13_q [3];
  logic [RSW-1:0]       rs13_q;
  logic                 vld13_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld13_q <= 1'b0;
    end else begin
      vld13_q <= vld12;
    end
  end

  always_ff @(posedge clk_i) begin
    c13_q[0] <= (CW'(w12[0]) <<< FRAC_BITS) + CW'(uxs);
    c13_q[1] <= (CW'(w12[1]) <<< FRAC_BITS) + CW'(uys) - CW'(htc);
    c13_q[2] <= (CW'(w12[2]) <<< FRAC_BITS) + CW'(uzs);
    rs13_q   <= rs12;
  end

  // Squared distance and squared radius sum.
  logic signed [LSW-1:0]  lsh;
  logic signed [SQW-1:0]  sqx, sqy, sqz;
  logic signed [LIMW-1:0] lim;

  assign lsh = {1'b0, rs13_q, {FRAC_BITS{1'b0}}};

  cco_mul #(.AW(CW), .BW(CW), .PW(SQW)) u_mul_sqx (
    .clk_i, .a_i(c13_q[0]), .b_i(c13_q[0]), .p_o(sqx));
  cco_mul #(.AW(CW), .BW(CW), .PW(SQW)) u_mul_sqy (
    .clk_i, .a_i(c13_q[1]), .b_i(c13_q[1]), .p_o(sqy));
  cco_mul #(.AW(CW), .BW(CW), .PW(SQW)) u_mul_sqz (
    .clk_i, .a_i(c13_q[2]), .b_i(c13_q[2]), .p_o(sqz));
  cco_mul #(.AW(LSW), .BW(LSW), .PW(LIMW)) u_mul_lim (
    .clk_i, .a_i(lsh), .b_i(lsh), .p_o(lim));

  logic vld14_q, vld15_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld14_q <= 1'b0;
      vld15_q <= 1'b0;
    end else begin
      vld14_q <= vld13_q;
      vld15_q <= vld14_q;
    end
  end

  logic signed [DDW-1:0] dd;
  logic                  overlap_d;

  assign dd        = DDW'(sqx) + DDW'(sqy) + DDW'(sqz);
  assign overlap_d = CMPW'(dd) <= CMPW'(lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vld15_q;
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_o <= overlap_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("Accepted item produced no result at the pipeline latency.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("Result strobe without a matching accepted item.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("Busy raised although the pipeline never stalls.");

endmodule
`default_nettype wire
